// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the slot allocator.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising edge, masked while reset is asserted
`define SAG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sag assertion failed");

// Property checked on every rising edge, reset included
`define SAG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sag assertion failed");

`endif

// ----- sv/sag_pkg.sv -----
// Shared codes and fixed field widths for the slot allocator.
// No dependencies; used by the top level and the port checker.
package sag_pkg;

    // Operation codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_ALLOC  = 3'd0,
        MODE_LOOKUP = 3'd1,
        MODE_LOCK   = 3'd2,
        MODE_UNLOCK = 3'd3,
        MODE_FREE   = 3'd4
    } mode_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_INVALID    = 3'd1,
        STAT_BUSY       = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_NOT_LOCKED = 3'd4
    } status_t;

    // Fixed word field widths
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 24;
    localparam int SLOT_W   = 8;
    localparam int HOST_W   = 8;
    localparam int GEN_FW   = 8;
    localparam int COUNT_W  = 9;

    // Window size after reset
    localparam int START_WINDOW = 16;

    // Free-slot search works on groups of this many slots
    localparam int GROUP_W     = 16;
    localparam int GROUP_IDX_W = 4;

endpackage

// ----- sv/slot_allocator_with_generations_unit.sv -----
// Slot allocator with generation ids: top level, control and slot marks.
// Depends on sag_pkg and sag_gen_mem (generation count storage).
//
//  channel | dir | handshake        | word
//  s_      | in  | s_valid/s_ready  | mode, id_in, slot_in
//  m_      | out | m_valid/m_ready  | status, id_out, slot_out, used_count
//  cfg_    | in  | cfg_wr_en only   | host number
//
// One word is worked on at a time. Allocate steps through grow at accept, group
// summary, group pick, slot pick plus generation read and write-back, which
// registers the result; it skips to write-back if a full window cannot grow. The
// other operations go to check/update, lookup reading its generation at accept.
// The engine takes the next word the cycle after the result is registered.
// A result stalled on m_ready holds the engine in its last step.
// Reset is synchronous; no clearing pass is needed.
module slot_allocator_with_generations_unit #(
    parameter int NUM_SLOTS = 256,
    parameter int GROW_STEP = 16,
    parameter int GEN_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // request
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [23:0] s_id_in,
    input  logic [7:0]  s_slot_in,
    // result
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [23:0] m_id_out,
    output logic [7:0]  m_slot_out,
    output logic [8:0]  m_used_count
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int SUM_W = $clog2(NUM_SLOTS + GROW_STEP + 1);
    localparam int GW    = sag_pkg::GROUP_W;
    localparam int BIT_W = sag_pkg::GROUP_IDX_W;
    localparam int NGRP  = (NUM_SLOTS + GW - 1) / GW;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int POS_W = GRP_W + BIT_W;
    localparam int WIN_INIT = (sag_pkg::START_WINDOW < NUM_SLOTS) ?
                              sag_pkg::START_WINDOW : NUM_SLOTS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_PICK,
        ST_BIT,
        ST_FIN
    } state_t;

    // control state
    state_t                       state_reg, state_next;
    logic [NUM_SLOTS-1:0]         used_reg, used_next;
    logic [NUM_SLOTS-1:0]         locked_reg, locked_next;
    logic [CNT_W-1:0]             window_reg, window_next;
    logic [IDX_W-1:0]             scan_reg, scan_next;
    logic [CNT_W-1:0]             in_use_reg, in_use_next;
    logic [sag_pkg::HOST_W-1:0]   host_reg, host_next;
    logic                         m_valid_reg, m_valid_next;

    // working registers
    logic [sag_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [sag_pkg::ID_W-1:0]     id_reg, id_next;
    logic [sag_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic                         full_reg, full_next;
    logic [NGRP-1:0]              grp_hi_reg, grp_hi_next;
    logic [NGRP-1:0]              grp_any_reg, grp_any_next;
    logic [GRP_W-1:0]             sel_grp_reg, sel_grp_next;
    logic                         sel_hi_reg, sel_hi_next;
    logic                         found_reg, found_next;
    logic [IDX_W-1:0]             pos_reg, pos_next;

    // result word
    logic [sag_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [sag_pkg::ID_W-1:0]     id_out_reg, id_out_next;
    logic [sag_pkg::SLOT_W-1:0]   slot_out_reg, slot_out_next;
    logic [sag_pkg::COUNT_W-1:0]  count_reg, count_next;

    // search terms
    logic [NGRP*GW-1:0]           used_pad;
    logic [GW-1:0]                elig [NGRP];
    logic [GW-1:0]                ahead [NGRP];
    logic [GW-1:0]                cand;
    logic [BIT_W-1:0]             bit_pick;
    logic [POS_W-1:0]             pos_full;
    logic [GRP_W-1:0]             hi_grp, any_grp;
    logic                         hi_found;

    // generation memory port
    logic                         gen_rd_en;
    logic [IDX_W-1:0]             gen_rd_addr;
    logic                         gen_wr_en;
    logic [GEN_BITS-1:0]          gen_wr_data;
    logic [GEN_BITS-1:0]          gen_rd_data;

    // misc
    logic                         accept;
    logic                         out_free;
    logic [SUM_W-1:0]             grown;
    logic [CNT_W-1:0]             win_eff;
    logic [CNT_W-1:0]             pos_inc;
    logic [IDX_W-1:0]             lk_idx;
    logic [IDX_W-1:0]             s_idx;
    logic                         lk_in_win;
    logic                         s_in_win;

    sag_gen_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (GEN_BITS)
    ) u_gen_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (gen_rd_en),
        .rd_addr (gen_rd_addr),
        .wr_en   (gen_wr_en),
        .wr_addr (pos_reg),
        .wr_data (gen_wr_data),
        .rd_data (gen_rd_data)
    );

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Per-slot free-in-window and at-or-after-scan-point terms, grouped
    always_comb begin
        used_pad = '1;
        used_pad[NUM_SLOTS-1:0] = used_reg;
        for (int g = 0; g < NGRP; g++) begin
            for (int b = 0; b < GW; b++) begin
                elig[g][b]  = !used_pad[g*GW + b] && ((g*GW + b) < int'(window_reg));
                ahead[g][b] = (g*GW + b) >= int'(scan_reg);
            end
        end
    end

    // First group with a free slot, preferring those at or after the scan point
    always_comb begin
        hi_found = 1'b0;
        hi_grp   = '0;
        any_grp  = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_hi_reg[g]) begin
                hi_found = 1'b1;
                hi_grp   = GRP_W'(g);
            end
            if (grp_any_reg[g]) begin
                any_grp = GRP_W'(g);
            end
        end
    end

    // First free slot inside the chosen group
    always_comb begin
        cand     = elig[sel_grp_reg] & (sel_hi_reg ? ahead[sel_grp_reg] : '1);
        bit_pick = '0;
        for (int b = GW - 1; b >= 0; b--) begin
            if (cand[b]) begin
                bit_pick = BIT_W'(b);
            end
        end
        pos_full = {sel_grp_reg, bit_pick};
    end

    // Index decode for lookup and slot operations
    assign lk_idx    = id_reg[IDX_W-1:0];
    assign s_idx     = slot_reg[IDX_W-1:0];
    assign lk_in_win = int'(id_reg[7:0]) < int'(window_reg);
    assign s_in_win  = int'(slot_reg) < int'(window_reg);
    assign pos_inc   = CNT_W'(pos_reg) + CNT_W'(1);
    assign grown     = SUM_W'(window_reg) + SUM_W'(GROW_STEP);

    // Next-state and datapath
    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        locked_next   = locked_reg;
        window_next   = window_reg;
        scan_next     = scan_reg;
        in_use_next   = in_use_reg;
        host_next     = cfg_wr_en ? cfg_wr_data : host_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mode_next     = mode_reg;
        id_next       = id_reg;
        slot_next     = slot_reg;
        full_next     = full_reg;
        grp_hi_next   = grp_hi_reg;
        grp_any_next  = grp_any_reg;
        sel_grp_next  = sel_grp_reg;
        sel_hi_next   = sel_hi_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        id_out_next   = id_out_reg;
        slot_out_next = slot_out_reg;
        count_next    = count_reg;
        gen_rd_en     = 1'b0;
        gen_rd_addr   = s_id_in[IDX_W-1:0];
        gen_wr_en     = 1'b0;
        gen_wr_data   = gen_rd_data + GEN_BITS'(1);
        win_eff       = window_reg;

        case (state_reg)
            // Take a word; allocate first grows the window when all of it is in use
            ST_IDLE: begin
                if (accept) begin
                    mode_next  = s_mode;
                    id_next    = s_id_in;
                    slot_next  = s_slot_in;
                    full_next  = 1'b0;
                    state_next = ST_FIN;
                    if (s_mode == sag_pkg::MODE_ALLOC) begin
                        if (in_use_reg >= window_reg) begin
                            if (grown > SUM_W'(NUM_SLOTS)) begin
                                full_next = 1'b1;
                            end else begin
                                win_eff = CNT_W'(grown);
                            end
                        end
                        if (!full_next) begin
                            window_next = win_eff;
                            if (CNT_W'(scan_reg) >= win_eff) begin
                                scan_next = '0;
                            end
                            state_next = ST_SUM;
                        end
                    end else if (s_mode == sag_pkg::MODE_LOOKUP) begin
                        gen_rd_en = 1'b1;
                    end
                end
            end

            // Per-group free summaries
            ST_SUM: begin
                for (int g = 0; g < NGRP; g++) begin
                    grp_hi_next[g]  = |(elig[g] & ahead[g]);
                    grp_any_next[g] = |elig[g];
                end
                state_next = ST_PICK;
            end

            // Choose the group, wrapping to the start if nothing lies ahead
            ST_PICK: begin
                found_next   = |grp_any_reg;
                sel_hi_next  = hi_found;
                sel_grp_next = hi_found ? hi_grp : any_grp;
                state_next   = ST_BIT;
            end

            // Choose the slot and fetch its generation
            ST_BIT: begin
                pos_next    = IDX_W'(pos_full);
                gen_rd_en   = found_reg;
                gen_rd_addr = IDX_W'(pos_full);
                state_next  = ST_FIN;
            end

            // Check, update the slot marks and register the result word
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    status_next   = sag_pkg::STAT_INVALID;
                    id_out_next   = '0;
                    slot_out_next = '0;
                    state_next    = ST_IDLE;
                    case (mode_reg)
                        sag_pkg::MODE_ALLOC: begin
                            if (full_reg || !found_reg) begin
                                status_next = sag_pkg::STAT_FULL;
                            end else begin
                                status_next       = sag_pkg::STAT_OK;
                                gen_wr_en         = 1'b1;
                                used_next[pos_reg]   = 1'b1;
                                locked_next[pos_reg] = 1'b1;
                                in_use_next       = in_use_reg + CNT_W'(1);
                                scan_next         = (pos_inc >= window_reg) ?
                                                    '0 : IDX_W'(pos_inc);
                                slot_out_next     = sag_pkg::SLOT_W'(pos_reg);
                                id_out_next       = {host_reg,
                                                     sag_pkg::GEN_FW'(gen_wr_data),
                                                     sag_pkg::SLOT_W'(pos_reg)};
                            end
                        end
                        sag_pkg::MODE_LOOKUP: begin
                            if (!lk_in_win || !used_reg[lk_idx]) begin
                                status_next = sag_pkg::STAT_INVALID;
                            end else if (locked_reg[lk_idx]) begin
                                status_next = sag_pkg::STAT_BUSY;
                            end else if ((sag_pkg::GEN_FW'(gen_rd_data) != id_reg[15:8]) ||
                                         (id_reg[23:16] != host_reg)) begin
                                status_next = sag_pkg::STAT_INVALID;
                            end else begin
                                status_next         = sag_pkg::STAT_OK;
                                locked_next[lk_idx] = 1'b1;
                                slot_out_next       = id_reg[7:0];
                            end
                        end
                        sag_pkg::MODE_LOCK: begin
                            if (!s_in_win) begin
                                status_next = sag_pkg::STAT_INVALID;
                            end else if (locked_reg[s_idx]) begin
                                status_next = sag_pkg::STAT_BUSY;
                            end else begin
                                status_next        = sag_pkg::STAT_OK;
                                locked_next[s_idx] = 1'b1;
                                slot_out_next      = slot_reg;
                            end
                        end
                        sag_pkg::MODE_UNLOCK: begin
                            if (!s_in_win) begin
                                status_next = sag_pkg::STAT_INVALID;
                            end else if (!locked_reg[s_idx]) begin
                                status_next = sag_pkg::STAT_NOT_LOCKED;
                            end else begin
                                status_next        = sag_pkg::STAT_OK;
                                locked_next[s_idx] = 1'b0;
                            end
                        end
                        sag_pkg::MODE_FREE: begin
                            if (!s_in_win || !used_reg[s_idx]) begin
                                status_next = sag_pkg::STAT_INVALID;
                            end else if (locked_reg[s_idx]) begin
                                status_next = sag_pkg::STAT_BUSY;
                            end else begin
                                status_next      = sag_pkg::STAT_OK;
                                used_next[s_idx] = 1'b0;
                                if (in_use_reg != '0) begin
                                    in_use_next = in_use_reg - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            status_next = sag_pkg::STAT_INVALID;
                        end
                    endcase
                    // count goes out with the status
                    count_next = sag_pkg::COUNT_W'(in_use_next);
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and result word registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= NUM_SLOTS'(1);
            locked_reg  <= '0;
            window_reg  <= CNT_W'(WIN_INIT);
            scan_reg    <= '0;
            in_use_reg  <= CNT_W'(1);
            host_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            locked_reg  <= locked_next;
            window_reg  <= window_next;
            scan_reg    <= scan_next;
            in_use_reg  <= in_use_next;
            host_reg    <= host_next;
            m_valid_reg <= m_valid_next;
        end
        // result fields need no reset, m_valid_reg qualifies them
        status_reg   <= status_next;
        id_out_reg   <= id_out_next;
        slot_out_reg <= slot_out_next;
        count_reg    <= count_next;
    end

    // Working registers
    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        slot_reg     <= slot_next;
        full_reg     <= full_next;
        grp_hi_reg   <= grp_hi_next;
        grp_any_reg  <= grp_any_next;
        sel_grp_reg  <= sel_grp_next;
        sel_hi_reg   <= sel_hi_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_id_out     = id_out_reg;
    assign m_slot_out   = slot_out_reg;
    assign m_used_count = count_reg;

endmodule

// ----- sv/sag_gen_mem.sv -----
// Generation count memory: one write port, one registered read port.
// Per-entry valid bits give the reset contents (entry 0 reads 1, others 0).
module sag_gen_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [DATA_W-1:0] rd_raw_reg;
    logic              rd_written_reg;
    logic              rd_zero_reg;

    // Storage array, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    // Written marks and read-side tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_written_reg <= written_reg[rd_addr];
                rd_zero_reg    <= (rd_addr == '0);
            end
        end
    end

    // Unwritten entries show their reset value
    always_comb begin
        if (rd_written_reg) begin
            rd_data = rd_raw_reg;
        end else if (rd_zero_reg) begin
            rd_data = DATA_W'(1);
        end else begin
            rd_data = '0;
        end
    end

endmodule

// ----- sv/sag_checker.sv -----
// Port-level checker for the slot allocator, bound to the top level.
// Depends on sag_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sag_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [23:0] m_id_out,
    input logic [7:0]  m_slot_out,
    input logic [8:0]  m_used_count
);

    // A stalled result word holds
    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_id_out) &&
            $stable(m_slot_out) && $stable(m_used_count);
    endproperty

    // Failed operations report no id and no slot
    property p_fail_clear;
        m_valid && (m_status != sag_pkg::STAT_OK) |->
            (m_id_out == 24'd0) && (m_slot_out == 8'd0);
    endproperty

    `SAG_ASSERT(a_out_hold, aclk, aresetn, p_out_hold)

    `SAG_ASSERT(a_fail_clear, aclk, aresetn, p_fail_clear)

    // One word in flight: the engine is busy right after an accept
    `SAG_ASSERT(a_one_in_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // Reset empties the result register
    `SAG_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind slot_allocator_with_generations_unit sag_checker u_sag_checker (.*);
